### sv/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

    localparam int JOB_DEPTH_DEF = 4;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;
    localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
    localparam logic [20:0] SUPP_BASE        = 21'h010000;
    localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST       = 21'h00D800;
    localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO_BYTE     = 21'h000080;
    localparam logic [20:0] MIN_THREE_BYTE   = 21'h000800;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_replacement;
        logic        last_of_run;
    } unit_item_t;

    // One decoded byte: rep_count replacements first, then data_count real units.
    typedef struct packed {
        logic [2:0]  rep_count;
        logic [1:0]  data_count;
        logic [15:0] unit0;
        logic [15:0] unit1;
    } job_t;

endpackage

### sv/u8u16_front.sv
// Byte classifier: tracks the pending sequence and builds at most one output job per byte.
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  byte_item_t byte_item,
    input  logic       job_ready,
    output logic       job_valid,
    output job_t       job
);

    logic [1:0]  pend_reg, pend_next;
    logic [2:0]  len_reg, len_next;
    logic [20:0] cp_reg, cp_next;

    logic        accept;
    logic [7:0]  b;
    logic        consumed;
    logic        bad;
    logic [20:0] cp_ext;
    logic [20:0] v;
    logic [2:0]  reps;
    logic [1:0]  datas;
    logic [15:0] u0;
    logic [15:0] u1;

    assign accept = push && job_ready;
    assign b      = byte_item.in_byte;

    always_comb
    begin
        pend_next = pend_reg;
        len_next  = len_reg;
        cp_next   = cp_reg;
        consumed  = 1'b0;
        bad       = 1'b0;
        reps      = 3'd0;
        datas     = 2'd0;
        u0        = REPLACEMENT_UNIT;
        u1        = REPLACEMENT_UNIT;
        cp_ext    = {cp_reg[14:0], b[5:0]};
        v         = cp_ext - SUPP_BASE;

        if (len_reg != 3'd0)
        begin
            if (b[7:6] == 2'b10 && pend_reg != 2'd0)
            begin
                consumed  = 1'b1;
                cp_next   = cp_ext;
                pend_next = pend_reg - 2'd1;
                if (pend_next == 2'd0)
                begin
                    bad = (len_reg == 3'd2 && cp_ext < MIN_TWO_BYTE) ||
                          (len_reg == 3'd3 && cp_ext < MIN_THREE_BYTE) ||
                          (len_reg == 3'd4 && cp_ext < SUPP_BASE) ||
                          cp_ext > MAX_CODE_POINT ||
                          (cp_ext >= SURR_FIRST && cp_ext <= SURR_LAST);
                    if (bad)
                        reps = len_reg;
                    else if (cp_ext < SUPP_BASE)
                    begin
                        datas = 2'd1;
                        u0    = cp_ext[15:0];
                    end
                    else
                    begin
                        datas = 2'd2;
                        u0    = HIGH_SURR_BASE + {6'd0, v[19:10]};
                        u1    = LOW_SURR_BASE + {6'd0, v[9:0]};
                    end
                    pend_next = 2'd0;
                    len_next  = 3'd0;
                    cp_next   = '0;
                end
            end
            else
            begin
                // broken sequence: replace each byte held so far
                if (len_reg >= {1'b0, pend_reg})
                    reps = len_reg - {1'b0, pend_reg};
                pend_next = 2'd0;
                len_next  = 3'd0;
                cp_next   = '0;
            end
        end

        if (!consumed)
        begin
            if (b[7] == 1'b0)
            begin
                datas = 2'd1;
                u0    = {8'd0, b};
            end
            else if (b[7:5] == 3'b110)
            begin
                cp_next   = {16'd0, b[4:0]};
                len_next  = 3'd2;
                pend_next = 2'd1;
            end
            else if (b[7:4] == 4'b1110)
            begin
                cp_next   = {17'd0, b[3:0]};
                len_next  = 3'd3;
                pend_next = 2'd2;
            end
            else if (b[7:3] == 5'b11110)
            begin
                cp_next   = {18'd0, b[2:0]};
                len_next  = 3'd4;
                pend_next = 2'd3;
            end
            else
                reps = reps + 3'd1;
        end

        // text cut off inside a sequence
        if (byte_item.end_of_text && len_next != 3'd0)
        begin
            if (len_next >= {1'b0, pend_next})
                reps = reps + (len_next - {1'b0, pend_next});
            pend_next = 2'd0;
            len_next  = 3'd0;
            cp_next   = '0;
        end
    end

    assign job.rep_count  = reps;
    assign job.data_count = datas;
    assign job.unit0      = u0;
    assign job.unit1      = u1;
    assign job_valid      = accept && (reps != 3'd0 || datas != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
            len_reg  <= 3'd0;
            cp_reg   <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            len_reg  <= len_next;
            cp_reg   <= cp_next;
        end
    end

endmodule

### sv/u8u16_back.sv
// Job queue and unit serializer: hands out one UTF-16 unit per pop.
module u8u16_back
    import u8u16_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    input  job_t       job,
    output logic       job_ready,
    input  logic       pop,
    output logic       empty,
    output unit_item_t unit_item
);

    localparam int PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CW = $clog2(JOB_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(JOB_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(JOB_DEPTH);

    job_t          jobs [JOB_DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    idx_reg, idx_next;

    job_t          head;
    logic          wr_en;
    logic          rd_en;
    logic          take;
    logic          is_rep;
    logic [2:0]    total;
    logic [1:0]    data_idx;
    logic          at_last;

    assign job_ready = (cnt_reg != FULL_CNT);
    assign empty     = (cnt_reg == '0);
    assign head      = jobs[rd_reg];

    assign total    = head.rep_count + {1'b0, head.data_count};
    assign is_rep   = {1'b0, idx_reg} < head.rep_count;
    assign data_idx = idx_reg - head.rep_count[1:0];
    assign at_last  = ({1'b0, idx_reg} + 3'd1) == total;

    assign unit_item.code_unit      = is_rep ? REPLACEMENT_UNIT :
                                      (data_idx[0] ? head.unit1 : head.unit0);
    assign unit_item.is_replacement = is_rep;
    assign unit_item.last_of_run    = at_last;

    assign take  = pop && !empty;
    assign wr_en = job_valid && job_ready;
    assign rd_en = take && at_last;

    always_comb
    begin
        wr_next  = wr_en ? ((wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1)) : wr_reg;
        rd_next  = rd_en ? ((rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1)) : rd_reg;
        cnt_next = cnt_reg + CW'(wr_en) - CW'(rd_en);
        idx_next = idx_reg;
        if (take)
            idx_next = at_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            jobs[wr_reg] <= job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
            idx_reg <= 2'd0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

endmodule

### sv/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 stream decoder.
//
//  channel    handshake         payload
//  byte in    push / full       byte_item  (in_byte, end_of_text)
//  unit out   empty / pop       unit_item  (code_unit, is_replacement, last_of_run)
//
// One byte is taken per clock while the job queue has room; its units are
// queued in the same edge and reach the output behind any earlier queued units.
// Units leave one per pop, so a byte giving n units takes n pops; JOB_DEPTH
// jobs (bytes that gave units) can wait before full rises.
// Reset clears the sequence state and the queue; no clearing pass is needed.
module utf8_to_utf16_decoder
    import u8u16_pkg::*;
#(
    parameter int JOB_DEPTH = JOB_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  byte_item_t byte_item,
    output logic       empty,
    input  logic       pop,
    output unit_item_t unit_item
);

    logic job_valid;
    logic job_ready;
    job_t job;

    assign full = !job_ready;

    u8u16_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .byte_item (byte_item),
        .job_ready (job_ready),
        .job_valid (job_valid),
        .job       (job)
    );

    u8u16_back #(
        .JOB_DEPTH (JOB_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_ready (job_ready),
        .pop       (pop),
        .empty     (empty),
        .unit_item (unit_item)
    );

endmodule

### verif/utf8_to_utf16_decoder_tb.sv
// Self-checking testbench for the UTF-8 to UTF-16 stream decoder.
module utf8_to_utf16_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_REPORTS   = 30;
    localparam int RANDOM_BYTES  = 300;
    localparam int TAIL_BYTES    = 100;
    localparam int HOLD_CYCLES   = 120;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    byte_item_t byte_item = '0;
    logic       empty;
    logic       pop = 1'b0;
    unit_item_t unit_item;

    // decoder state as seen by the predictor
    logic [1:0]  cont_needed = '0;
    logic [2:0]  seq_len = '0;
    logic [20:0] partial_cp = '0;

    unit_item_t step_units[$];
    unit_item_t expected_units[$];

    int  errors = 0;
    int  bytes_sent = 0;
    int  units_checked = 0;
    int  input_stalls = 0;
    int  cycle_count = 0;
    int  sink_hold = 0;
    bit  idle_on = 1'b1;

    utf8_to_utf16_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_item (byte_item),
        .empty     (empty),
        .pop       (pop),
        .unit_item (unit_item)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic void queue_unit(input logic [15:0] code, input logic rep);
        unit_item_t u;
        u.code_unit      = code;
        u.is_replacement = rep;
        u.last_of_run    = 1'b0;
        step_units = {step_units, u};
    endfunction

    function automatic void go_idle();
        cont_needed = '0;
        seq_len     = '0;
        partial_cp  = '0;
    endfunction

    function automatic void replace_held_bytes();
        int held;
        held = int'(seq_len) - int'(cont_needed);
        for (int k = 0; k < held; k++)
            queue_unit(REPLACEMENT_UNIT, 1'b1);
        go_idle();
    endfunction

    function automatic void close_sequence();
        logic [20:0] cp;
        logic [20:0] v;
        logic        bad;
        cp  = partial_cp;
        bad = (seq_len == 3'd2 && cp < MIN_TWO_BYTE) ||
              (seq_len == 3'd3 && cp < MIN_THREE_BYTE) ||
              (seq_len == 3'd4 && cp < SUPP_BASE) ||
              cp > MAX_CODE_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST);
        if (bad)
        begin
            for (int k = 0; k < int'(seq_len); k++)
                queue_unit(REPLACEMENT_UNIT, 1'b1);
        end
        else if (cp < SUPP_BASE)
        begin
            queue_unit(cp[15:0], 1'b0);
        end
        else
        begin
            v = cp - SUPP_BASE;
            queue_unit(HIGH_SURR_BASE + {6'b0, v[19:10]}, 1'b0);
            queue_unit(LOW_SURR_BASE + {6'b0, v[9:0]}, 1'b0);
        end
        go_idle();
    endfunction

    function automatic void open_lead(input logic [7:0] b);
        if (b < 8'h80)
        begin
            queue_unit({8'h00, b}, 1'b0);
        end
        else if (b[7:5] == 3'b110)
        begin
            partial_cp  = {16'b0, b[4:0]};
            seq_len     = 3'd2;
            cont_needed = 2'd1;
        end
        else if (b[7:4] == 4'b1110)
        begin
            partial_cp  = {17'b0, b[3:0]};
            seq_len     = 3'd3;
            cont_needed = 2'd2;
        end
        else if (b[7:3] == 5'b11110)
        begin
            partial_cp  = {18'b0, b[2:0]};
            seq_len     = 3'd4;
            cont_needed = 2'd3;
        end
        else
        begin
            queue_unit(REPLACEMENT_UNIT, 1'b1);
        end
    endfunction

    // Work out the units one accepted byte gives and queue them.
    function automatic void decode_byte(input byte_item_t item);
        logic       taken;
        taken = 1'b0;
        step_units.delete();
        if (seq_len != 0)
        begin
            if (item.in_byte[7:6] == 2'b10 && cont_needed != 0)
            begin
                partial_cp  = {partial_cp[14:0], item.in_byte[5:0]};
                cont_needed = cont_needed - 2'd1;
                taken       = 1'b1;
                if (cont_needed == 0)
                    close_sequence();
            end
            else
            begin
                replace_held_bytes();
            end
        end
        if (!taken)
            open_lead(item.in_byte);
        // text ends with a sequence still open
        if (item.end_of_text && seq_len != 0)
            replace_held_bytes();
        if (step_units.size() != 0)
            step_units[step_units.size() - 1].last_of_run = 1'b1;
        expected_units = {expected_units, step_units};
    endfunction

    // ---------------- checking ----------------

    function automatic void flag_mismatch(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $error("%s: expected %h, got %h", field, want, got);
    endfunction

    always @(posedge clk)
    begin : unit_check
        unit_item_t want;
        if (rst_n && push && full)
            input_stalls++;
        if (rst_n && pop && !empty)
        begin
            if (expected_units.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("code_unit: expected none, got %h", unit_item.code_unit);
            end
            else
            begin
                want = expected_units.pop_front();
                units_checked++;
                if (unit_item.code_unit !== want.code_unit)
                    flag_mismatch("code_unit", want.code_unit, unit_item.code_unit);
                if (unit_item.is_replacement !== want.is_replacement)
                    flag_mismatch("is_replacement", {15'b0, want.is_replacement},
                                  {15'b0, unit_item.is_replacement});
                if (unit_item.last_of_run !== want.last_of_run)
                    flag_mismatch("last_of_run", {15'b0, want.last_of_run},
                                  {15'b0, unit_item.last_of_run});
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("utf8_to_utf16_decoder_tb: errors");
            $finish;
        end
    end

    // Result side: random stall bursts, plus a long hold when requested.
    initial
    begin : unit_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------

    // Offer one byte request; returns at the edge that accepts it.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        byte_item_t item;
        item.in_byte     = b;
        item.end_of_text = eot;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        push      <= 1'b1;
        byte_item <= item;
        do @(posedge clk); while (full);
        decode_byte(item);
        bytes_sent++;
    endtask

    // Encode cp in len bytes (overlong and out-of-range forms allowed), send the first keep.
    task automatic send_encoded(input logic [20:0] cp, input int len, input int keep,
                                input logic eot);
        logic [7:0] enc [4];
        enc[1] = 8'h80;
        enc[2] = 8'h80;
        enc[3] = 8'h80;
        case (len)
            1:
            begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            send_byte(enc[i], eot && i == keep - 1);
    endtask

    task automatic send_random_char();
        int          pick;
        int          len;
        logic [20:0] cp;
        logic        eot;
        pick = $urandom_range(0, 99);
        eot  = ($urandom_range(0, 15) == 0);
        if (pick < 25)
        begin
            send_encoded(21'($urandom_range(0, 'h7F)), 1, 1, eot);
        end
        else if (pick < 40)
        begin
            send_encoded(21'($urandom_range('h80, 'h7FF)), 2, 2, eot);
        end
        else if (pick < 55)
        begin
            send_encoded(21'($urandom_range('h800, 'hFFFF)), 3, 3, eot);
        end
        else if (pick < 70)
        begin
            send_encoded(21'($urandom_range('h10000, 'h10FFFF)), 4, 4, eot);
        end
        else if (pick < 80)
        begin
            // overlong, surrogate or above the code space
            case ($urandom_range(0, 2))
                0:
                begin
                    len = $urandom_range(2, 4);
                    cp  = (len == 2) ? 21'($urandom_range(0, 'h7F)) :
                          (len == 3) ? 21'($urandom_range(0, 'h7FF)) :
                                       21'($urandom_range(0, 'hFFFF));
                    send_encoded(cp, len, len, eot);
                end
                1:
                begin
                    send_encoded(21'($urandom_range('hD800, 'hDFFF)), 3, 3, eot);
                end
                default:
                begin
                    send_encoded(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, eot);
                end
            endcase
        end
        else if (pick < 90)
        begin
            // sequence cut short: the next byte breaks it, or the text ends
            len = $urandom_range(2, 4);
            cp  = 21'($urandom_range('h80, 'h10FFFF));
            send_encoded(cp, len, $urandom_range(1, len - 1), $urandom_range(0, 3) == 0);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)), eot);
        end
    endtask

    task automatic send_random_text(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_random_char();
    endtask

    // Stop offering and wait for every expected unit.
    task automatic wait_all_units();
        push <= 1'b0;
        do @(posedge clk); while (expected_units.size() != 0);
    endtask

    // ---------------- tests ----------------

    task automatic test_single_byte_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_valid_sequences();
        send_byte(8'hF4, 1'b0);     // U+10FFFF as a surrogate pair
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0);     // U+FFFD spelled out in the text
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBD, 1'b0);
    endtask

    task automatic test_bad_leads();
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_rejected_values();
        send_byte(8'hC0, 1'b0);     // overlong
        send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0);     // surrogate
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF5, 1'b0);     // above the code space
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    task automatic test_broken_sequence();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b0);
    endtask

    task automatic test_cut_off_at_end();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b1);
    endtask

    // Hold the result side so the block fills up and pushes back.
    task automatic test_output_stall();
        sink_hold = HOLD_CYCLES;
        for (int i = 0; i < 8; i++)
            send_encoded(21'($urandom_range('h10000, 'h10FFFF)), 4, 4, 1'b0);
        for (int i = 0; i < 8; i++)
            send_byte(8'($urandom_range('hF8, 'hFF)), 1'b0);
    endtask

    task automatic test_drain_pause();
        send_random_text(20);
        wait_all_units();
        send_random_text(20);
    endtask

    task automatic test_quiet_tail();
        idle_on = 1'b0;
        send_random_text(TAIL_BYTES);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_byte_extremes();
        test_valid_sequences();
        test_bad_leads();
        test_rejected_values();
        test_broken_sequence();
        test_cut_off_at_end();
        test_output_stall();
        test_drain_pause();
        send_random_text(RANDOM_BYTES);
        test_quiet_tail();
        wait_all_units();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d bytes sent (directed cases, random text, long output hold), %0d units checked",
                 bytes_sent, units_checked);
        $display("%0d cycles with a byte held back by full", input_stalls);
        if (errors == 0 && expected_units.size() == 0)
            $display("utf8_to_utf16_decoder_tb: clean");
        else
            $display("utf8_to_utf16_decoder_tb: errors");
        $finish;
    end

endmodule
